>>> design/mrm_pkg.sv
package mrm_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int MAX_PATTERN  = 8;
    localparam int WINDOW_BYTES = 8;

    localparam int COUNT_W = $clog2(BUFFER_BYTES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(BUFFER_BYTES - 1);

    localparam int LEN_W       = 4;
    localparam int PATTERN_W   = 64;
    localparam int TIMEOUT_W   = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [PATTERN_W-1:0] PATTERN_RESET = 64'd20299;
    localparam logic [LEN_W-1:0]     LENGTH_RESET  = 4'd2;

    localparam logic [PATTERN_W-1:0] WORD_ERROR = 64'h0000_0045_5252_4F52;
    localparam logic [PATTERN_W-1:0] WORD_FAIL  = 64'h0000_0000_4641_494C;
    localparam int ERROR_LEN = 5;
    localparam int FAIL_LEN  = 4;

    // command codes
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_FOUND   = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_ERROR   = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECT_PATTERN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECT_LENGTH  = 2'd1;

    typedef struct packed {
        logic [7:0] pat;
        logic       pat_used;
        logic [7:0] err;
        logic       err_used;
        logic [7:0] fail;
        logic       fail_used;
    } t_cell_ref;

    typedef struct packed {
        logic pat_ok;
        logic err_ok;
        logic fail_ok;
    } t_cell_hit;

endpackage

>>> design/mrm_if.sv
interface mrm_cmd_if;
    import mrm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           command;
    logic [7:0]           rx_byte;
    logic [TIMEOUT_W-1:0] timeout_ms;

    modport source (output valid, command, rx_byte, timeout_ms, input ready);
    modport sink (input valid, command, rx_byte, timeout_ms, output ready);
endinterface

interface mrm_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;

    modport source (output valid, status, input ready);
    modport sink (input valid, status, output ready);
endinterface

interface mrm_cfg_if;
    import mrm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [PATTERN_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> design/modem_response_matcher.sv
// Modem reply matcher. Takes one command item per clock: a received byte, a
// millisecond tick or a start. The last eight received bytes sit in a row of
// eight byte cells that shift on every appended byte; each cell compares the
// byte it is taking against the expected pattern and against "ERROR" and
// "FAIL", so the whole tail is checked in the cycle the byte arrives. A
// status item (found, timed out, error) is registered before it shows on the
// output. Results go through a two-entry output buffer, so
// the command channel stays ready at one item per cycle and drops ready only
// while both entries hold results that the sink has not taken. Configuration
// writes are always ready and must only be made while the block is idle.
module modem_response_matcher
    import mrm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mrm_cmd_if.sink   i_cmd_ch,
    mrm_cfg_if.sink   i_cfg_ch,
    mrm_rsp_if.source o_rsp_ch
);

    logic [PATTERN_W-1:0] r_expect_pattern;
    logic [LEN_W-1:0]     r_expect_length;

    logic [COUNT_W-1:0]   r_count, n_count;
    logic [TIMEOUT_W-1:0] r_time, n_time;
    logic                 r_armed, n_armed;
    logic                 r_zero_seen, n_zero_seen;

    logic                 w_fire;
    logic                 w_ready;
    logic                 w_full;
    logic                 w_shift;
    logic                 w_clear;
    logic [LEN_W-1:0]     w_plen;
    logic [TIMEOUT_W-1:0] w_time_dec;
    logic                 w_res;
    logic [1:0]           w_status;

    logic [7:0]              w_byte  [WINDOW_BYTES];
    logic [WINDOW_BYTES-1:0] w_valid;
    logic [WINDOW_BYTES-1:0] w_pat_ok;
    logic [WINDOW_BYTES-1:0] w_err_ok;
    logic [WINDOW_BYTES-1:0] w_fail_ok;

    assign w_fire     = i_cmd_ch.valid && w_ready;
    assign i_cmd_ch.ready = w_ready;
    assign i_cfg_ch.ready = 1'b1;
    assign w_full     = (r_count == COUNT_MAX);
    assign w_plen     = (r_expect_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                                : r_expect_length;
    assign w_shift    = w_fire && (i_cmd_ch.command == CMD_BYTE) && r_armed && !w_full;
    assign w_clear    = w_fire && (i_cmd_ch.command == CMD_START);
    assign w_time_dec = r_time - TIMEOUT_W'(1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_pattern <= PATTERN_RESET;
            r_expect_length  <= LENGTH_RESET;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                REG_EXPECT_PATTERN: r_expect_pattern <= i_cfg_ch.data;
                REG_EXPECT_LENGTH:  r_expect_length  <= i_cfg_ch.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // tail window: cell 0 holds the newest byte
    genvar k;
    generate
        for (k = 0; k < WINDOW_BYTES; k++) begin : g_cell
            t_cell_ref  w_ref;
            t_cell_hit  w_hit;
            logic [7:0] w_in_byte;
            logic       w_in_valid;

            if (k == 0) begin : g_head
                assign w_in_byte  = i_cmd_ch.rx_byte;
                assign w_in_valid = 1'b1;
            end else begin : g_link
                assign w_in_byte  = w_byte[k-1];
                assign w_in_valid = w_valid[k-1];
            end

            assign w_ref.pat       = r_expect_pattern[8*k +: 8];
            assign w_ref.pat_used  = (LEN_W'(k) < w_plen);
            assign w_ref.err       = WORD_ERROR[8*k +: 8];
            assign w_ref.err_used  = (k < ERROR_LEN);
            assign w_ref.fail      = WORD_FAIL[8*k +: 8];
            assign w_ref.fail_used = (k < FAIL_LEN);

            mrm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_clear (w_clear),
                .i_byte  (w_in_byte),
                .i_valid (w_in_valid),
                .i_ref   (w_ref),
                .o_byte  (w_byte[k]),
                .o_valid (w_valid[k]),
                .o_hit   (w_hit)
            );

            assign w_pat_ok[k]  = w_hit.pat_ok;
            assign w_err_ok[k]  = w_hit.err_ok;
            assign w_fail_ok[k] = w_hit.fail_ok;
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_time      = r_time;
        n_armed     = r_armed;
        n_zero_seen = r_zero_seen;
        w_res       = 1'b0;
        w_status    = STATUS_FOUND;
        if (w_fire) begin
            case (i_cmd_ch.command)
                CMD_START: begin
                    n_count     = '0;
                    n_zero_seen = 1'b0;
                    n_time      = i_cmd_ch.timeout_ms;
                    if (i_cmd_ch.timeout_ms == '0) begin
                        n_armed  = 1'b0;
                        w_res    = 1'b1;
                        w_status = STATUS_TIMEOUT;
                    end else begin
                        n_armed = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (r_armed) begin
                        n_time = w_time_dec;
                        if (w_time_dec == '0) begin
                            n_armed  = 1'b0;
                            w_res    = 1'b1;
                            w_status = STATUS_TIMEOUT;
                        end
                    end
                end
                CMD_BYTE: begin
                    if (r_armed && !w_full) begin
                        n_count = r_count + COUNT_W'(1);
                        if (w_plen == '0) begin
                            // empty pattern matches any first byte
                            n_armed  = 1'b0;
                            w_res    = 1'b1;
                            w_status = STATUS_FOUND;
                        end else begin
                            n_zero_seen = r_zero_seen || (i_cmd_ch.rx_byte == 8'd0);
                            if (!n_zero_seen) begin
                                if (&w_pat_ok) begin
                                    n_armed  = 1'b0;
                                    w_res    = 1'b1;
                                    w_status = STATUS_FOUND;
                                end else if ((&w_err_ok) || (&w_fail_ok)) begin
                                    n_armed  = 1'b0;
                                    w_res    = 1'b1;
                                    w_status = STATUS_ERROR;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_time      <= '0;
            r_armed     <= 1'b0;
            r_zero_seen <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_time      <= n_time;
            r_armed     <= n_armed;
            r_zero_seen <= n_zero_seen;
        end
    end

    mrm_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res),
        .i_status (w_status),
        .o_ready  (w_ready),
        .o_rsp    (o_rsp_ch)
    );

`ifndef SYNTH
    // any report leaves the block idle
    a_disarm_on_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res |=> !r_armed)
        else $error("block still armed after a report");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("stored count beyond buffer");

    // filled cells form a contiguous run from the newest end
    a_cells_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[WINDOW_BYTES-1:1] & ~w_valid[WINDOW_BYTES-2:0]) == '0)
        else $error("gap in tail window");

    a_empty_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (w_valid == '0))
        else $error("window holds bytes with empty count");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_ch.ready |-> o_rsp_ch.valid)
        else $error("command channel stalled with empty output");
`endif

endmodule

>>> design/mrm_cell.sv
module mrm_cell
    import mrm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    input  logic       i_valid,
    input  t_cell_ref  i_ref,
    output logic [7:0] o_byte,
    output logic       o_valid,
    output t_cell_hit  o_hit
);

    logic [7:0] r_byte;
    logic       r_valid;

    // compare on the byte about to be taken from the neighbor
    always_comb begin
        o_hit.pat_ok  = !i_ref.pat_used  || (i_valid && (i_byte == i_ref.pat));
        o_hit.err_ok  = !i_ref.err_used  || (i_valid && (i_byte == i_ref.err));
        o_hit.fail_ok = !i_ref.fail_used || (i_valid && (i_byte == i_ref.fail));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

>>> design/mrm_skid.sv
module mrm_skid
    import mrm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [1:0] i_status,
    output logic       o_ready,
    mrm_rsp_if.source  o_rsp
);

    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic       r_skid_valid;
    logic [1:0] r_skid_status;
    logic       w_pop;

    assign w_pop   = r_out_valid && o_rsp.ready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out_status <= r_skid_status;
            end
        end else if (i_push) begin
            if (r_out_valid && !w_pop) begin
                r_skid_status <= i_status;
            end else begin
                r_out_status <= i_status;
            end
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;

endmodule

>>> tb/sv/tb_modem_response_matcher.sv
`timescale 1ns / 1ps

module tb_modem_response_matcher;
    import mrm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_SETUPS = 11;
    localparam int SETUP_ITEMS = 55;
    localparam logic [7:0] FILL_CHAR = 8'h78;

    typedef struct {
        logic [1:0]           command;
        logic [7:0]           rx_byte;
        logic [TIMEOUT_W-1:0] timeout_ms;
        bit                   hold;
    } t_cmd_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrm_cmd_if cmd_ch ();
    mrm_cfg_if cfg_ch ();
    mrm_rsp_if rsp_ch ();

    modem_response_matcher dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .i_cfg_ch (cfg_ch),
        .o_rsp_ch (rsp_ch)
    );

    // shadow copy of the matcher registers and state
    logic [PATTERN_W-1:0] pat_reg = PATTERN_RESET;
    logic [LEN_W-1:0]     len_reg = LENGTH_RESET;
    logic [63:0]          win_bytes = '0;
    logic [COUNT_W-1:0]   text_len = '0;
    logic [TIMEOUT_W-1:0] ms_left = '0;
    bit                   waiting = 1'b0;
    bit                   nul_seen = 1'b0;

    t_cmd_item  cmd_queue[$];
    t_cmd_item  item_on_bus;
    logic [1:0] pending_status[$];

    int items_queued = 0;
    int items_taken = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int errors = 0;
    int cycles = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int send_gap = 0;
    int send_burst = 0;
    int recv_stall = 0;
    int recv_burst = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pattern_bytes();
        return (len_reg > MAX_PATTERN) ? MAX_PATTERN : int'(len_reg);
    endfunction

    function automatic bit tail_ends_with(input logic [63:0] word, input int n);
        logic [63:0] mask;
        mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        if (text_len < n)
            return 1'b0;
        return (win_bytes & mask) == (word & mask);
    endfunction

    // advances the shadow state by one item, returns 1 when a status item follows
    function automatic bit predict_status(input t_cmd_item it, output logic [1:0] status);
        int plen;
        status = STATUS_FOUND;
        if (it.command == CMD_START) begin
            win_bytes = '0;
            text_len = '0;
            nul_seen = 1'b0;
            ms_left = it.timeout_ms;
            if (it.timeout_ms == '0) begin
                waiting = 1'b0;
                status = STATUS_TIMEOUT;
                return 1'b1;
            end
            waiting = 1'b1;
            return 1'b0;
        end
        if (!waiting || it.command == CMD_UNUSED)
            return 1'b0;
        if (it.command == CMD_TICK) begin
            ms_left = ms_left - 1'b1;
            if (ms_left == '0) begin
                waiting = 1'b0;
                status = STATUS_TIMEOUT;
                return 1'b1;
            end
            return 1'b0;
        end
        // text full, byte dropped
        if (text_len >= COUNT_MAX)
            return 1'b0;
        text_len = text_len + 1'b1;
        win_bytes = {win_bytes[55:0], it.rx_byte};
        plen = pattern_bytes();
        if (plen == 0) begin
            waiting = 1'b0;
            return 1'b1;
        end
        if (it.rx_byte == 8'h00)
            nul_seen = 1'b1;
        if (nul_seen)
            return 1'b0;
        if (tail_ends_with(pat_reg, plen)) begin
            waiting = 1'b0;
            return 1'b1;
        end
        if (tail_ends_with(WORD_ERROR, ERROR_LEN) || tail_ends_with(WORD_FAIL, FAIL_LEN)) begin
            waiting = 1'b0;
            status = STATUS_ERROR;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_item(input logic [1:0] c, input logic [7:0] b,
                             input logic [TIMEOUT_W-1:0] t, input bit hold = 1'b0);
        t_cmd_item it;
        it.command = c;
        it.rx_byte = (c == CMD_BYTE) ? b : 8'($urandom);
        it.timeout_ms = (c == CMD_START) ? t : TIMEOUT_W'($urandom);
        it.hold = hold;
        cmd_queue.push_back(it);
        items_queued++;
    endtask

    // sends the n low bytes of word, oldest first
    task automatic push_word(input logic [63:0] word, input int n);
        for (int k = n - 1; k >= 0; k--)
            push_item(CMD_BYTE, word[8 * k +: 8], '0);
    endtask

    task automatic add_session();
        int n;
        int r;
        int plen;
        int k;
        logic [TIMEOUT_W-1:0] tmo;
        plen = pattern_bytes();
        r = $urandom_range(0, 99);
        if (r < 5)
            tmo = '0;
        else if (r < 12)
            tmo = TIMEOUT_W'($urandom_range(0, 65535));
        else
            tmo = TIMEOUT_W'($urandom_range(1, 30));
        push_item(CMD_START, '0, tmo, $urandom_range(0, 99) < 8);
        n = $urandom_range(0, 24);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 20)
                push_item(CMD_BYTE, 8'($urandom_range(32, 126)), '0);
            else if (r < 25)
                push_item(CMD_BYTE, 8'($urandom), '0);
            else if (r < 40)
                push_item(CMD_TICK, '0, '0);
            else if (r < 55)
                push_word(pat_reg, plen);
            else if (r < 62)
                push_word(WORD_ERROR, ERROR_LEN);
            else if (r < 68)
                push_word(WORD_FAIL, FAIL_LEN);
            else if (r < 72)
                push_item(CMD_BYTE, 8'h00, '0);
            else if (r < 75)
                push_item(CMD_UNUSED, '0, '0);
            else if (r < 78)
                push_item(CMD_START, '0, TIMEOUT_W'($urandom_range(1, 30)));
            else if (plen > 0) begin
                // leading part of the pattern only
                k = $urandom_range(1, plen);
                push_word(pat_reg >> (8 * (plen - k)), k);
            end
        end
        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(5, 35)) push_item(CMD_TICK, '0, '0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [PATTERN_W-1:0] d);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_EXPECT_PATTERN)
            pat_reg = d;
        else if (idx == REG_EXPECT_LENGTH)
            len_reg = d[LEN_W-1:0];
        reg_writes++;
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        write_reg(REG_EXPECT_LENGTH, {60'({$urandom, $urandom}), len});
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (items_taken != items_queued || pending_status.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // command driver
    always @(posedge i_clk) begin
        logic [1:0] st;
        bit next_valid;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else begin
            next_valid = cmd_ch.valid;
            if (cmd_ch.valid && cmd_ch.ready) begin
                items_taken++;
                if (predict_status(item_on_bus, st))
                    pending_status.push_back(st);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (cmd_queue.size() != 0 &&
                             !(cmd_queue[0].hold && pending_status.size() != 0)) begin
                    item_on_bus = cmd_queue.pop_front();
                    cmd_ch.command    <= item_on_bus.command;
                    cmd_ch.rx_byte    <= item_on_bus.rx_byte;
                    cmd_ch.timeout_ms <= item_on_bus.timeout_ms;
                    next_valid = 1'b1;
                    if (send_burst > 0)
                        send_burst--;
                    else if ($urandom_range(0, 99) < 3)
                        send_burst = $urandom_range(30, 150);
                    else
                        send_gap = pick_gap();
                end
            end
            cmd_ch.valid <= next_valid;
        end
    end

    // status monitor and sink stalls
    always @(posedge i_clk) begin
        logic [1:0] want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_checked++;
                status_seen[rsp_ch.status]++;
                if (pending_status.size() == 0) begin
                    $display("%0t: status item with none pending: expected none, actual %0d",
                             $time, rsp_ch.status);
                    errors++;
                end else begin
                    want = pending_status.pop_front();
                    if (rsp_ch.status !== want) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want, rsp_ch.status);
                        errors++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (recv_burst > 0)
                    recv_burst--;
                else if ($urandom_range(0, 99) < 3)
                    recv_burst = $urandom_range(30, 150);
                else if ($urandom_range(0, 99) < 25)
                    recv_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [PATTERN_W-1:0] rnd_pat;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.command = CMD_BYTE;
        cmd_ch.rx_byte = '0;
        cmd_ch.timeout_ms = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_EXPECT_PATTERN;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items on the reset setup ("OK")
        push_item(CMD_BYTE, 8'h4F, '0);
        push_item(CMD_TICK, '0, '0);
        push_item(CMD_UNUSED, '0, '0);
        push_item(CMD_START, '0, 16'd0);
        push_item(CMD_START, '0, 16'hFFFF);
        push_item(CMD_START, '0, 16'd3);
        push_item(CMD_UNUSED, '0, '0);
        push_word(64'h4F4B, 2);
        push_item(CMD_START, '0, 16'd100);
        push_word(WORD_ERROR, ERROR_LEN);
        push_item(CMD_START, '0, 16'd100);
        push_word(WORD_FAIL, FAIL_LEN);
        // zero byte blocks the later match, only the timeout ends it
        push_item(CMD_START, '0, 16'd2);
        push_item(CMD_BYTE, 8'hFF, '0);
        push_item(CMD_BYTE, 8'h00, '0);
        push_word(64'h4F4B, 2);
        push_item(CMD_TICK, '0, '0);
        push_item(CMD_TICK, '0, '0);
        wait_idle();

        for (int s = 0; s < NUM_SETUPS; s++) begin
            case (s)
                1: begin
                    write_reg(REG_EXPECT_PATTERN, 64'h0000_0D0A_4F4B_0D0A);
                    write_length(4'd6);
                end
                2: write_length(4'd0);
                3: begin
                    for (int k = 0; k < 8; k++)
                        rnd_pat[8 * k +: 8] = 8'($urandom_range(1, 255));
                    write_reg(REG_EXPECT_PATTERN, rnd_pat);
                    write_length(4'd8);
                end
                4: begin
                    write_reg(REG_EXPECT_PATTERN, '1);
                    write_length(4'd15);
                end
                5: begin
                    write_reg(REG_EXPECT_PATTERN, '0);
                    write_length(4'd3);
                end
                6: write_reg(REG_EXPECT_PATTERN, 64'h0000_0000_004F_004B);
                7: begin
                    write_reg(REG_EXPECT_PATTERN, WORD_FAIL);
                    write_length(4'd4);
                end
                8: begin
                    write_reg(REG_EXPECT_PATTERN, 64'h0000_0052_4541_4459);
                    write_length(4'd5);
                end
                9: begin
                    write_reg(REG_EXPECT_PATTERN, {$urandom, $urandom});
                    write_length(4'($urandom_range(1, 8)));
                end
                10: begin
                    write_reg(REG_EXPECT_PATTERN, 64'h4F4B);
                    write_length(4'd1);
                end
                default: begin
                    // text filling up: the last free slot still matches
                    push_item(CMD_START, '0, 16'd5);
                    repeat (253) push_item(CMD_BYTE, FILL_CHAR, '0);
                    push_word(64'h4F4B, 2);
                    // bytes past the end are dropped, only the timeout ends it
                    push_item(CMD_START, '0, 16'd5, 1'b1);
                    repeat (258) push_item(CMD_BYTE, FILL_CHAR, '0);
                    push_word(WORD_ERROR, ERROR_LEN);
                    repeat (6) push_item(CMD_TICK, '0, '0);
                end
            endcase
            begin
                int start_count;
                start_count = items_queued;
                while (items_queued - start_count < SETUP_ITEMS)
                    add_session();
            end
            wait_idle();
        end

        $display("%0d command items in %0d setups, %0d register writes",
                 items_taken, NUM_SETUPS, reg_writes);
        $display("%0d status items checked: %0d found, %0d timed out, %0d error",
                 results_checked, status_seen[STATUS_FOUND], status_seen[STATUS_TIMEOUT],
                 status_seen[STATUS_ERROR]);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
